[hw/rtl/lspg_pkg.sv]
package lspg_pkg;

	localparam int PIXEL_COUNT_DEF = 16;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 9;

	localparam logic [CFG_INDEX_W-1:0] REG_MODE       = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_BRIGHTNESS = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_SPEED      = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_BASE_RED   = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_BASE_GREEN = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_BASE_BLUE  = 3'd5;

	localparam logic [3:0] MODE_IDLE        = 4'd0;
	localparam logic [3:0] MODE_OFF         = 4'd1;
	localparam logic [3:0] MODE_COLOR       = 4'd2;
	localparam logic [3:0] MODE_WIPE        = 4'd3;
	localparam logic [3:0] MODE_CHASE       = 4'd4;
	localparam logic [3:0] MODE_RAINBOW     = 4'd5;
	localparam logic [3:0] MODE_CYCLE       = 4'd6;
	localparam logic [3:0] MODE_CANDLE      = 4'd7;
	localparam logic [3:0] MODE_TUNGSTEN40  = 4'd8;
	localparam logic [3:0] MODE_TUNGSTEN100 = 4'd9;
	localparam logic [3:0] MODE_HALOGEN     = 4'd10;
	localparam logic [3:0] MODE_CARBON_ARC  = 4'd11;
	localparam logic [3:0] MODE_NOON_SUN    = 4'd12;
	localparam logic [3:0] MODE_PURE_WHITE  = 4'd13;
	localparam logic [3:0] MODE_OVERCAST    = 4'd14;
	localparam logic [3:0] MODE_CLEAR_SKY   = 4'd15;

	// floor(x/100) = (x * RECIP_100) >> RECIP_100_SHIFT for x < 65536
	localparam logic [16:0] RECIP_100       = 17'd83887;
	localparam int          RECIP_100_SHIFT = 23;
	// floor(x/10) = (x * RECIP_10) >> RECIP_10_SHIFT for x < 1024
	localparam logic [7:0]  RECIP_10        = 8'd205;
	localparam int          RECIP_10_SHIFT  = 11;

	localparam logic [8:0] SPEED_MAX  = 9'd510;
	localparam logic [5:0] SOLID_WAIT = 6'd9;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CALC,
		ST_SCALE,
		ST_LOAD,
		ST_HOLD
	} lspg_state_t;

	typedef struct packed {
		logic start;
		logic calc;
		logic scale;
		logic load;
		logic next_px;
		logic frame_done;
	} lspg_cmd_t;

	typedef struct packed {
		logic emit;
		logic last_px;
		logic off_frame;
		logic out_taken;
	} lspg_sts_t;

	function automatic logic [23:0] preset_rgb(input logic [3:0] m);
		logic [23:0] c;
		case (m)
			MODE_CANDLE:      c = {8'd255, 8'd147, 8'd41};
			MODE_TUNGSTEN40:  c = {8'd255, 8'd197, 8'd143};
			MODE_TUNGSTEN100: c = {8'd255, 8'd214, 8'd170};
			MODE_HALOGEN:     c = {8'd255, 8'd241, 8'd224};
			MODE_CARBON_ARC:  c = {8'd255, 8'd250, 8'd244};
			MODE_NOON_SUN:    c = {8'd255, 8'd255, 8'd251};
			MODE_PURE_WHITE:  c = {8'd255, 8'd255, 8'd255};
			MODE_OVERCAST:    c = {8'd201, 8'd226, 8'd255};
			MODE_CLEAR_SKY:   c = {8'd64, 8'd156, 8'd255};
			default:          c = 24'd0;
		endcase
		return c;
	endfunction

	function automatic logic [23:0] wheel(input logic [7:0] pos);
		logic [7:0] p;
		logic [7:0] t;
		logic [23:0] c;
		p = 8'd255 - pos;
		if (p < 8'd85) begin
			t = p + (p << 1);
			c = {8'd255 - t, 8'd0, t};
		end else if (p < 8'd170) begin
			p = p - 8'd85;
			t = p + (p << 1);
			c = {8'd0, t, 8'd255 - t};
		end else begin
			p = p - 8'd170;
			t = p + (p << 1);
			c = {t, 8'd255 - t, 8'd0};
		end
		return c;
	endfunction

endpackage

[hw/rtl/lspg_ctrl.sv]
module lspg_ctrl
	import lspg_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  lspg_sts_t sts,
	output lspg_cmd_t cmd
);

	lspg_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.start = 1'b1;
					if (sts.emit) begin
						state_d = ST_CALC;
					end
				end
			end
			ST_CALC: begin
				cmd.calc = 1'b1;
				state_d  = ST_SCALE;
			end
			ST_SCALE: begin
				cmd.scale = 1'b1;
				state_d   = ST_LOAD;
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
				state_d  = ST_HOLD;
			end
			ST_HOLD: begin
				if (sts.out_taken) begin
					if (!sts.last_px) begin
						cmd.next_px = 1'b1;
						state_d     = ST_CALC;
					end else begin
						cmd.frame_done = 1'b1;
						state_d        = sts.off_frame ? ST_CALC : ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

[hw/rtl/lspg_datapath.sv]
module lspg_datapath
	import lspg_pkg::*;
#(
	parameter int PIXEL_COUNT = PIXEL_COUNT_DEF
)(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   restart,
	input  lspg_cmd_t              cmd,
	output lspg_sts_t              sts,
	input  logic                   out_stall,
	output logic                   out_valid,
	output logic [4:0]             pixel_index,
	output logic [7:0]             red,
	output logic [7:0]             green,
	output logic [7:0]             blue,
	output logic                   frame_end,
	output logic                   run_end
);

	localparam int IW = $clog2(PIXEL_COUNT);
	localparam int CW = IW + 1;
	localparam logic [IW-1:0] LAST_PX  = IW'(PIXEL_COUNT - 1);
	localparam logic [7:0]    PC8      = 8'(PIXEL_COUNT);
	localparam logic [7:0]    WIPE_LEN = 8'(2 * PIXEL_COUNT);
	localparam logic [7:0]    HUE_STEP = 8'(256 / PIXEL_COUNT);
	localparam logic [CW-1:0] HUE_REM  = CW'(256 % PIXEL_COUNT);
	localparam logic [CW-1:0] HUE_N    = CW'(PIXEL_COUNT);

	logic [3:0]  mode_q;
	logic [7:0]  bright_q;
	logic [8:0]  speed_q;
	logic [7:0]  base_r_q, base_g_q, base_b_q;

	logic [23:0]   frame_q [PIXEL_COUNT];
	logic [7:0]    phase_q;
	logic [5:0]    wait_q;
	logic          pend_q;
	logic          off_q;
	logic [IW-1:0] px_q;
	logic [1:0]    m3_q;
	logic [7:0]    hue_q;
	logic [CW-1:0] rem_q;
	logic          wr_q;
	logic [15:0]   prod_q [3];
	logic          out_valid_q;

	logic [7:0]  ph0, ph_norm;
	logic [5:0]  wc0, reload;
	logic        pend0;
	logic [8:0]  sp_clamp, sp_diff;
	logic [16:0] w_prod;
	logic [5:0]  w_ticks;
	logic        wr_d;
	logic [23:0] raw;
	logic [7:0]  scaled [3];
	logic [CW-1:0] rem_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			bright_q <= '0;
			speed_q  <= '0;
			base_r_q <= '0;
			base_g_q <= '0;
			base_b_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_MODE:       mode_q   <= cfg_data[3:0];
				REG_BRIGHTNESS: bright_q <= cfg_data[7:0];
				REG_SPEED:      speed_q  <= cfg_data;
				REG_BASE_RED:   base_r_q <= cfg_data[7:0];
				REG_BASE_GREEN: base_g_q <= cfg_data[7:0];
				REG_BASE_BLUE:  base_b_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		ph0   = restart ? 8'd0 : phase_q;
		wc0   = restart ? 6'd0 : wait_q;
		pend0 = restart ? 1'b0 : pend_q;

		sp_clamp = (speed_q > SPEED_MAX) ? SPEED_MAX : speed_q;
		sp_diff  = SPEED_MAX - sp_clamp;
		w_prod   = 17'(sp_diff * RECIP_10);
		w_ticks  = 6'(w_prod >> RECIP_10_SHIFT);
		if (mode_q inside {[MODE_WIPE:MODE_CYCLE]}) begin
			reload = (w_ticks == 6'd0) ? 6'd0 : w_ticks - 6'd1;
		end else begin
			reload = SOLID_WAIT;
		end

		ph_norm = ph0;
		if (mode_q == MODE_WIPE && ph0 >= WIPE_LEN) begin
			ph_norm = 8'd0;
		end
		if (mode_q == MODE_CHASE && ph0 >= 8'd3) begin
			ph_norm = 8'd0;
		end
	end

	always_comb begin
		wr_d = 1'b1;
		raw  = 24'd0;
		case (mode_q)
			MODE_IDLE, MODE_OFF: begin
				raw = 24'd0;
			end
			MODE_COLOR: begin
				raw = {base_r_q, base_g_q, base_b_q};
			end
			MODE_WIPE: begin
				if (phase_q < PC8) begin
					wr_d = (8'(px_q) == phase_q);
					raw  = {base_r_q, base_g_q, base_b_q};
				end else begin
					wr_d = (8'(px_q) == phase_q - PC8);
				end
			end
			MODE_CHASE: begin
				wr_d = (m3_q == phase_q[1:0]);
				raw  = off_q ? 24'd0 : {base_r_q, base_g_q, base_b_q};
			end
			MODE_RAINBOW: begin
				raw = wheel(8'(px_q) + phase_q);
			end
			MODE_CYCLE: begin
				raw = wheel(hue_q + phase_q);
			end
			default: begin
				raw = preset_rgb(mode_q);
			end
		endcase
	end

	always_comb begin
		logic [32:0] m;
		logic [9:0]  q;
		for (int c = 0; c < 3; c++) begin
			m = 33'(prod_q[c]) * 33'(RECIP_100);
			q = 10'(m >> RECIP_100_SHIFT);
			scaled[c] = (q > 10'd255) ? 8'd255 : q[7:0];
		end
	end

	assign rem_sum = rem_q + HUE_REM;

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			wr_q      <= wr_d;
			prod_q[0] <= 16'(raw[23:16] * bright_q);
			prod_q[1] <= 16'(raw[15:8] * bright_q);
			prod_q[2] <= 16'(raw[7:0] * bright_q);
		end
		if (cmd.load) begin
			pixel_index <= 5'(px_q);
			red         <= frame_q[px_q][23:16];
			green       <= frame_q[px_q][15:8];
			blue        <= frame_q[px_q][7:0];
			frame_end   <= (px_q == LAST_PX);
			run_end     <= (px_q == LAST_PX) && !off_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PIXEL_COUNT; i++) begin
				frame_q[i] <= 24'd0;
			end
			phase_q     <= '0;
			wait_q      <= '0;
			pend_q      <= 1'b0;
			off_q       <= 1'b0;
			px_q        <= '0;
			m3_q        <= '0;
			hue_q       <= '0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				if (mode_q == MODE_IDLE) begin
					phase_q <= ph0;
					wait_q  <= wc0;
					pend_q  <= pend0;
				end else if (wc0 != 6'd0) begin
					phase_q <= ph0;
					wait_q  <= wc0 - 6'd1;
					pend_q  <= pend0;
				end else begin
					phase_q <= ph_norm;
					wait_q  <= reload;
					pend_q  <= (mode_q == MODE_CHASE) && pend0;
					off_q   <= (mode_q == MODE_CHASE) && pend0;
					px_q    <= '0;
					m3_q    <= '0;
					hue_q   <= '0;
					rem_q   <= '0;
				end
			end
			if (cmd.scale && wr_q) begin
				frame_q[px_q] <= {scaled[0], scaled[1], scaled[2]};
			end
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.next_px) begin
				px_q <= px_q + 1'b1;
				m3_q <= (m3_q == 2'd2) ? 2'd0 : m3_q + 2'd1;
				if (rem_sum >= HUE_N) begin
					rem_q <= rem_sum - HUE_N;
					hue_q <= hue_q + HUE_STEP + 8'd1;
				end else begin
					rem_q <= rem_sum;
					hue_q <= hue_q + HUE_STEP;
				end
			end
			if (cmd.frame_done) begin
				px_q  <= '0;
				m3_q  <= '0;
				hue_q <= '0;
				rem_q <= '0;
				if (off_q) begin
					off_q   <= 1'b0;
					phase_q <= (phase_q[1:0] == 2'd2) ? 8'd0 : phase_q + 8'd1;
				end else begin
					case (mode_q)
						MODE_WIPE: begin
							phase_q <= (phase_q == WIPE_LEN - 8'd1) ? 8'd0 : phase_q + 8'd1;
						end
						MODE_CHASE: begin
							pend_q <= 1'b1;
						end
						MODE_RAINBOW, MODE_CYCLE: begin
							phase_q <= phase_q + 8'd1;
						end
						default: ;
					endcase
				end
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign sts.emit      = (mode_q != MODE_IDLE) && (wc0 == 6'd0);
	assign sts.last_px   = (px_q == LAST_PX);
	assign sts.off_frame = off_q;
	assign sts.out_taken = out_valid_q && !out_stall;

endmodule

[hw/rtl/led_strip_pattern_generator_core.sv]
// LED strip pattern generator. Each input word is one 10 ms tick; a tick that
// falls due produces a whole frame of PIXEL_COUNT pixel words, and a theatre
// chase tick that first blanks the previous step produces two frames. A tick
// that produces nothing is taken without leaving the idle state. Each pixel of
// a producing tick passes through color select, brightness multiply,
// divide-by-100 reciprocal multiply and frame store write, then the output
// register. Input stall is high while a tick is being worked on.
// Configuration is written through cfg_wr_en/cfg_index/cfg_data while idle.
module led_strip_pattern_generator_core
	import lspg_pkg::*;
#(
	parameter int PIXEL_COUNT = PIXEL_COUNT_DEF
)(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   restart,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [4:0]             pixel_index,
	output logic [7:0]             red,
	output logic [7:0]             green,
	output logic [7:0]             blue,
	output logic                   frame_end,
	output logic                   run_end
);

	lspg_cmd_t cmd;
	lspg_sts_t sts;

	lspg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	lspg_datapath #(
		.PIXEL_COUNT (PIXEL_COUNT)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.restart     (restart),
		.cmd         (cmd),
		.sts         (sts),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.pixel_index (pixel_index),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.frame_end   (frame_end),
		.run_end     (run_end)
	);

endmodule

[dv/tb_top.sv]
module tb_top
	import lspg_pkg::*;
();

	localparam int NPIX = PIXEL_COUNT_DEF;
	localparam int DRAIN_CYCLES = 1 + 8 * NPIX + 20;
	localparam int CYCLE_LIMIT = 2000000;

	typedef struct {
		logic [4:0] idx;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic       fe;
		logic       re;
	} pixel_word_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_wr_en = 0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 0;
	logic in_stall;
	logic restart = 0;
	logic out_valid;
	logic out_stall = 0;
	logic [4:0] pixel_index;
	logic [7:0] red, green, blue;
	logic frame_end, run_end;

	led_strip_pattern_generator_core DUT (.*);

	pixel_word_t pixels_due[$];
	int errors = 0;
	int cycles = 0;
	bit quiet = 0;
	int out_stall_left = 0;

	logic [3:0] p_mode;
	logic [7:0] p_bright, p_r, p_g, p_b;
	logic [8:0] p_speed;
	logic [23:0] strip [NPIX];
	logic [7:0] p_phase;
	logic [5:0] p_wait;
	bit p_chase_off;

	initial forever #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("led_strip_pattern_generator_core verification failed");
			$finish;
		end
	end

	function automatic logic [7:0] scaled(input logic [7:0] v);
		int unsigned t;
		t = (v * p_bright) / 100;
		return (t > 255) ? 8'd255 : t[7:0];
	endfunction

	function automatic void paint(input int i, input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		strip[i] = {scaled(r), scaled(g), scaled(b)};
	endfunction

	function automatic void paint_wheel(input int i, input logic [7:0] pos);
		int unsigned p;
		p = 255 - pos;
		if (p < 85)
			paint(i, 8'(255 - p * 3), 8'd0, 8'(p * 3));
		else if (p < 170)
			paint(i, 8'd0, 8'((p - 85) * 3), 8'(255 - (p - 85) * 3));
		else
			paint(i, 8'((p - 170) * 3), 8'(255 - (p - 170) * 3), 8'd0);
	endfunction

	function automatic void queue_frame();
		pixel_word_t w;
		for (int i = 0; i < NPIX; i++) begin
			w.idx = 5'(i);
			{w.r, w.g, w.b} = strip[i];
			w.fe = (i == NPIX - 1);
			w.re = 1'b0;
			pixels_due.push_back(w);
		end
	endfunction

	function automatic void predict_tick(input bit rs);
		int unsigned period;
		logic [23:0] c;
		if (rs) begin
			p_phase = 0;
			p_wait = 0;
			p_chase_off = 0;
		end
		if (p_mode == MODE_IDLE)
			return;
		if (p_wait != 0) begin
			p_wait--;
			return;
		end
		if (p_mode >= MODE_WIPE && p_mode <= MODE_CYCLE) begin
			period = (510 - ((p_speed > SPEED_MAX) ? SPEED_MAX : p_speed)) / 10;
			if (period == 0)
				period = 1;
		end else begin
			period = 10;
		end
		if (p_mode != MODE_CHASE)
			p_chase_off = 0;
		case (p_mode)
			MODE_OFF: begin
				for (int i = 0; i < NPIX; i++)
					strip[i] = '0;
			end
			MODE_COLOR: begin
				for (int i = 0; i < NPIX; i++)
					paint(i, p_r, p_g, p_b);
			end
			MODE_WIPE: begin
				if (p_phase >= 2 * NPIX)
					p_phase = 0;
				if (p_phase < NPIX)
					paint(p_phase, p_r, p_g, p_b);
				else
					strip[p_phase - NPIX] = '0;
				p_phase = 8'((p_phase + 1) % (2 * NPIX));
			end
			MODE_CHASE: begin
				if (p_phase >= 3)
					p_phase = 0;
				if (p_chase_off) begin
					for (int i = p_phase; i < NPIX; i += 3)
						strip[i] = '0;
					queue_frame();
					p_phase = 8'((p_phase + 1) % 3);
				end
				for (int i = p_phase; i < NPIX; i += 3)
					paint(i, p_r, p_g, p_b);
				p_chase_off = 1;
			end
			MODE_RAINBOW: begin
				for (int i = 0; i < NPIX; i++)
					paint_wheel(i, 8'(i + p_phase));
				p_phase++;
			end
			MODE_CYCLE: begin
				for (int i = 0; i < NPIX; i++)
					paint_wheel(i, 8'((i * 256) / NPIX + p_phase));
				p_phase++;
			end
			default: begin
				case (p_mode)
					MODE_CANDLE:      c = {8'd255, 8'd147, 8'd41};
					MODE_TUNGSTEN40:  c = {8'd255, 8'd197, 8'd143};
					MODE_TUNGSTEN100: c = {8'd255, 8'd214, 8'd170};
					MODE_HALOGEN:     c = {8'd255, 8'd241, 8'd224};
					MODE_CARBON_ARC:  c = {8'd255, 8'd250, 8'd244};
					MODE_NOON_SUN:    c = {8'd255, 8'd255, 8'd251};
					MODE_PURE_WHITE:  c = {8'd255, 8'd255, 8'd255};
					MODE_OVERCAST:    c = {8'd201, 8'd226, 8'd255};
					default:          c = {8'd64, 8'd156, 8'd255};
				endcase
				for (int i = 0; i < NPIX; i++)
					paint(i, c[23:16], c[15:8], c[7:0]);
			end
		endcase
		queue_frame();
		pixels_due[pixels_due.size() - 1].re = 1'b1;
		p_wait = 6'((period - 1) & 63);
	endfunction

	// output side: random stall bursts, checker
	always @(posedge clk) begin
		if (quiet) begin
			out_stall <= 0;
		end else if (out_stall_left > 0) begin
			out_stall_left <= out_stall_left - 1;
			out_stall <= 1;
		end else if ($urandom_range(0, 5) == 0) begin
			out_stall_left <= $urandom_range(0, 7);
			out_stall <= 1;
		end else begin
			out_stall <= 0;
		end
	end

	always @(posedge clk) begin
		pixel_word_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (pixels_due.size() == 0) begin
				$error("unexpected pixel word index %0d", pixel_index);
				errors++;
			end else begin
				w = pixels_due.pop_front();
				if (pixel_index !== w.idx) begin
					$error("pixel_index exp %0d got %0d", w.idx, pixel_index);
					errors++;
				end
				if (red !== w.r) begin
					$error("red exp %0d got %0d", w.r, red);
					errors++;
				end
				if (green !== w.g) begin
					$error("green exp %0d got %0d", w.g, green);
					errors++;
				end
				if (blue !== w.b) begin
					$error("blue exp %0d got %0d", w.b, blue);
					errors++;
				end
				if (frame_end !== w.fe) begin
					$error("frame_end exp %0d got %0d", w.fe, frame_end);
					errors++;
				end
				if (run_end !== w.re) begin
					$error("run_end exp %0d got %0d", w.re, run_end);
					errors++;
				end
			end
		end
	end

	task automatic send_tick(input bit rs);
		in_valid <= 1;
		restart <= rs;
		do
			@(posedge clk);
		while (in_stall);
		predict_tick(rs);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	task automatic settle();
		in_valid <= 0;
		while (pixels_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_regs(input logic [3:0] m, input logic [7:0] br, input logic [8:0] sp,
			input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		logic [8:0] vals [6];
		vals = '{m, br, sp, r, g, b};
		for (int i = 0; i < 6; i++) begin
			cfg_wr_en <= 1;
			cfg_index <= CFG_INDEX_W'(i);
			cfg_data <= vals[i];
			@(posedge clk);
		end
		cfg_wr_en <= 0;
		p_mode = m;
		p_bright = br;
		p_speed = sp;
		p_r = r;
		p_g = g;
		p_b = b;
	endtask

	task automatic test_solid_modes();
		write_regs(MODE_COLOR, 8'd255, 9'd0, 8'd255, 8'd0, 8'd170);
		send_tick(0);
		settle();
		write_regs(MODE_OFF, 8'd100, 9'd0, 8'd0, 8'd0, 8'd0);
		send_tick(1);
		settle();
		for (int m = MODE_CANDLE; m <= MODE_CLEAR_SKY; m++) begin
			write_regs(4'(m), (m % 2) ? 8'd100 : 8'd37, 9'd0, 8'd0, 8'd0, 8'd0);
			send_tick(1);
			settle();
		end
	endtask

	task automatic test_wipe_and_chase();
		write_regs(MODE_WIPE, 8'd0, 9'd511, 8'd200, 8'd17, 8'd255);
		repeat (3) send_tick(0);
		settle();
		write_regs(MODE_CHASE, 8'd150, 9'd510, 8'd90, 8'd255, 8'd3);
		repeat (4) send_tick(0);
		settle();
	endtask

	task automatic test_rainbows_and_restart();
		write_regs(MODE_RAINBOW, 8'd100, 9'd495, 8'd0, 8'd0, 8'd0);
		repeat (3) send_tick(0);
		send_tick(1);
		settle();
		write_regs(MODE_CYCLE, 8'd64, 9'd500, 8'd0, 8'd0, 8'd0);
		send_tick(1);
		settle();
		write_regs(MODE_IDLE, 8'd64, 9'd500, 8'd0, 8'd0, 8'd0);
		send_tick(1);
		send_tick(0);
		settle();
	endtask

	task automatic test_random(input int phases, input int ticks);
		logic [3:0] m;
		logic [8:0] sp;
		for (int ph = 0; ph < phases; ph++) begin
			m = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) :
				4'($urandom_range(3, 6));
			if ($urandom_range(0, 9) == 0)
				m = MODE_IDLE;
			sp = ($urandom_range(0, 7) == 0) ? 9'($urandom_range(0, 511)) :
				9'($urandom_range(480, 511));
			write_regs(m, 8'($urandom_range(0, 255)), sp, 8'($urandom), 8'($urandom),
				8'($urandom));
			for (int t = 0; t < ticks; t++)
				send_tick($urandom_range(0, 19) == 0);
			settle();
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1;
		p_phase = 0;
		p_wait = 0;
		p_chase_off = 0;
		for (int i = 0; i < NPIX; i++)
			strip[i] = '0;
		@(posedge clk);
		test_solid_modes();
		test_wipe_and_chase();
		test_rainbows_and_restart();
		test_random(8, 40);
		quiet = 1;
		test_random(1, 50);
		if (errors == 0)
			$display("led_strip_pattern_generator_core verification clean");
		else
			$display("led_strip_pattern_generator_core verification failed");
		$finish;
	end
endmodule
